>>> hw/rtl/u16u8_pkg.sv
package u16u8_pkg;

    // Code unit ranges and code point limits.
    localparam logic [15:0] SurrHighFirst = 16'hD800;
    localparam logic [15:0] SurrHighLast  = 16'hDBFF;
    localparam logic [15:0] SurrLowFirst  = 16'hDC00;
    localparam logic [15:0] SurrLowLast   = 16'hDFFF;
    localparam logic [20:0] PlaneOneBase  = 21'h10000;
    localparam logic [5:0]  SurrPrefix    = 6'b110110;

    // Work queue between the front and the back.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Encoded length of a UTF-8 sequence, stored as length minus one.
    typedef enum logic [1:0] {
        LEN_ONE   = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2,
        LEN_FOUR  = 2'd3
    } t_len;

    // Work for one accepted item: an optional lone surrogate that was held
    // (always three bytes), then an optional code point.
    typedef struct packed {
        logic        pre_valid;
        logic [9:0]  pre_bits;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        eot;
    } t_desc;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_len utf8_len(input logic [20:0] cp);
        t_len len;
        if (cp < 21'h80) begin
            len = LEN_ONE;
        end else if (cp < 21'h800) begin
            len = LEN_TWO;
        end else if (cp < PlaneOneBase) begin
            len = LEN_THREE;
        end else begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input t_len len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_ONE: begin
                b = cp[7:0];
            end
            LEN_TWO: begin
                b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            LEN_THREE: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_FOUR: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/utf16_to_utf8_converter_core.sv
// An item's first byte is offered once its work entry has gone through the queue and
// been loaded into the serializer. Throughput: one byte per cycle at the output while
// pop is high, so one item per cycle while items make a single byte each.
// A high surrogate that is only held makes no byte and costs no serializer time.
// Reset (i_rst_n low at a clock edge) empties the queue, drops any held surrogate
// and idles the serializer; a new text may begin right after.
module utf16_to_utf8_converter_core import u16u8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_text_done
);

    // The front classifies each item against the held high surrogate and turns it
    // into a work entry: an optional lone surrogate to emit first, then an optional
    // code point. The entry goes into a small queue, so the front keeps taking items
    // while the back is still serializing bytes of earlier ones.
    t_desc  front_desc;
    logic   front_push;
    logic   front_accept;
    logic   front_held;
    t_desc  q_desc;
    t_qstat q_stat;
    logic   back_load;

    u16u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .i_qstat       (q_stat),
        .o_accept      (front_accept),
        .o_desc_push   (front_push),
        .o_desc        (front_desc),
        .o_held        (front_held)
    );

    // The queue is the only backpressure the producer sees.
    assign full = q_stat.full;

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_desc  (front_desc),
        .i_pop   (back_load),
        .o_desc  (q_desc),
        .o_qstat (q_stat)
    );

    // The back holds one entry in registers and steps through its bytes, one per
    // accepted pop. It reloads from the queue in the same cycle the final byte of
    // the current entry is taken, so bytes leave without gaps.
    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (q_desc),
        .i_qstat       (q_stat),
        .o_load        (back_load),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    // The end of a text never leaves a surrogate held.
    a_eot_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_accept && i_end_of_text |=> !front_held)
        else $error("surrogate still held after end of text");

    // The end of a text always produces a work entry.
    a_eot_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_accept && i_end_of_text |-> front_push)
        else $error("end of text produced no bytes");

    // The whole-text mark only appears on the final byte of an item.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_text_done |-> o_last_of_run)
        else $error("text done without last of run");

    // The serializer loads only entries that exist.
    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_load |-> !q_stat.empty)
        else $error("serializer loaded from an empty queue");

endmodule

>>> hw/rtl/u16u8_front.sv
module u16u8_front import u16u8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_text,
    input  t_qstat      i_qstat,
    output logic        o_accept,
    output logic        o_desc_push,
    output t_desc       o_desc,
    output logic        o_held
);

    logic       r_held;
    logic [9:0] r_held_bits;
    logic       n_held;
    logic [9:0] n_held_bits;
    logic       is_high;
    logic       is_low;

    assign o_accept = i_push && !i_qstat.full;
    assign is_high  = (i_code_unit >= SurrHighFirst) && (i_code_unit <= SurrHighLast);
    assign is_low   = (i_code_unit >= SurrLowFirst) && (i_code_unit <= SurrLowLast);

    always_comb begin
        n_held      = r_held;
        n_held_bits = r_held_bits;
        o_desc      = '0;
        o_desc.eot  = i_end_of_text;
        if (r_held && is_low) begin
            // Surrogate pair: combine into one supplementary code point.
            o_desc.main_valid = 1'b1;
            o_desc.main_cp    = PlaneOneBase + {1'b0, r_held_bits, i_code_unit[9:0]};
            n_held            = 1'b0;
        end else begin
            o_desc.pre_valid = r_held;
            o_desc.pre_bits  = r_held_bits;
            if (is_high && !i_end_of_text) begin
                n_held      = 1'b1;
                n_held_bits = i_code_unit[9:0];
            end else begin
                o_desc.main_valid = 1'b1;
                o_desc.main_cp    = {5'd0, i_code_unit};
                n_held            = 1'b0;
            end
        end
        if (!o_accept) begin
            n_held      = r_held;
            n_held_bits = r_held_bits;
        end
    end

    assign o_desc_push = o_accept && (o_desc.pre_valid || o_desc.main_valid);
    assign o_held      = r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_held_bits <= '0;
        end else begin
            r_held      <= n_held;
            r_held_bits <= n_held_bits;
        end
    end

endmodule

>>> hw/rtl/u16u8_queue.sv
module u16u8_queue import u16u8_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_desc  i_desc,
    input  logic   i_pop,
    output t_desc  o_desc,
    output t_qstat o_qstat
);

    t_desc                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueueCntW-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_qstat.full  = (r_count == QueueCntW'(QueueDepth));
    assign o_qstat.empty = (r_count == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_desc        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

>>> hw/rtl/u16u8_back.sv
module u16u8_back import u16u8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  t_qstat     i_qstat,
    output logic       o_load,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_text_done
);

    t_desc       r_desc;
    logic        r_busy;
    logic        r_phase_pre;
    logic [1:0]  r_idx;
    logic        n_busy;
    logic        n_phase_pre;
    logic [1:0]  n_idx;
    logic [20:0] cur_cp;
    t_len        cur_len;
    logic        seg_last;
    logic        run_last;
    logic        take;

    assign cur_cp   = r_phase_pre ? {5'd0, SurrPrefix, r_desc.pre_bits} : r_desc.main_cp;
    assign cur_len  = r_phase_pre ? LEN_THREE : utf8_len(r_desc.main_cp);
    assign seg_last = (r_idx == 2'(cur_len));
    assign run_last = seg_last && (!r_phase_pre || !r_desc.main_valid);

    assign o_empty       = !r_busy;
    assign o_out_byte    = utf8_byte(cur_cp, cur_len, r_idx);
    assign o_last_of_run = run_last;
    assign o_text_done   = run_last && r_desc.eot;

    assign take   = r_busy && i_pop;
    assign o_load = !i_qstat.empty && (!r_busy || (take && run_last));

    always_comb begin
        n_busy      = r_busy;
        n_phase_pre = r_phase_pre;
        n_idx       = r_idx;
        if (o_load) begin
            n_busy      = 1'b1;
            n_phase_pre = i_desc.pre_valid;
            n_idx       = 2'd0;
        end else if (take) begin
            if (!seg_last) begin
                n_idx = r_idx + 2'd1;
            end else if (!run_last) begin
                n_phase_pre = 1'b0;
                n_idx       = 2'd0;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase_pre <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_busy      <= n_busy;
            r_phase_pre <= n_phase_pre;
            r_idx       <= n_idx;
        end
        if (o_load) begin
            r_desc <= i_desc;
        end
    end

endmodule

>>> test/tb_utf16_to_utf8_converter_core.sv
`timescale 1ns / 100ps

// One expected UTF-8 byte together with its two marker bits.
typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
} utf8_byte_t;

// Transcoding scoreboard: mirrors the surrogate hold state and keeps the
// bytes the block still owes in order.
class utf8_scoreboard;
    bit         held_valid;
    bit [9:0]   held_bits;
    utf8_byte_t run_q[$];
    utf8_byte_t owed_q[$];
    int unsigned units_seen;
    int unsigned pairs_seen;
    int unsigned lone_seen;
    int unsigned bytes_checked;
    int unsigned mismatches;

    function new();
        held_valid    = 1'b0;
        held_bits     = '0;
        units_seen    = 0;
        pairs_seen    = 0;
        lone_seen     = 0;
        bytes_checked = 0;
        mismatches    = 0;
    endfunction

    function void add_byte(bit [7:0] b);
        utf8_byte_t e;
        e.data = b;
        e.last = 1'b0;
        e.done = 1'b0;
        run_q.push_back(e);
    endfunction

    // Encodes one code point as 1 to 4 bytes.
    function void add_point(bit [20:0] cp);
        if (cp < 21'h80) begin
            add_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_byte(8'hC0 | 8'(cp >> 6));
            add_byte(8'h80 | 8'(cp & 21'h3F));
        end else if (cp < 21'h10000) begin
            add_byte(8'hE0 | 8'(cp >> 12));
            add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
            add_byte(8'h80 | 8'(cp & 21'h3F));
        end else begin
            add_byte(8'hF0 | 8'(cp >> 18));
            add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
            add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
            add_byte(8'h80 | 8'(cp & 21'h3F));
        end
    endfunction

    function void note_unit(bit [15:0] cu, bit eot);
        bit        is_high;
        bit        is_low;
        bit [20:0] cp;
        is_high = (cu >= u16u8_pkg::SurrHighFirst) && (cu <= u16u8_pkg::SurrHighLast);
        is_low  = (cu >= u16u8_pkg::SurrLowFirst) && (cu <= u16u8_pkg::SurrLowLast);
        run_q.delete();
        units_seen++;
        if (held_valid && is_low) begin
            cp = 21'h10000 + {1'b0, held_bits, cu[9:0]};
            held_valid = 1'b0;
            held_bits  = '0;
            pairs_seen++;
            add_point(cp);
        end else begin
            if (held_valid) begin
                add_point({5'd0, 6'b110110, held_bits});
                held_valid = 1'b0;
                held_bits  = '0;
                lone_seen++;
            end
            if (is_high && !eot) begin
                held_valid = 1'b1;
                held_bits  = cu[9:0];
            end else begin
                add_point({5'd0, cu});
                if (is_high || is_low) begin
                    lone_seen++;
                end
            end
        end
        foreach (run_q[k]) begin
            run_q[k].last = (k == run_q.size() - 1);
            run_q[k].done = run_q[k].last && eot;
            owed_q.push_back(run_q[k]);
        end
    endfunction

    function void check_byte(bit [7:0] data, bit last, bit done);
        utf8_byte_t e;
        if (owed_q.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %02h last=%0b done=%0b",
                     $time, data, last, done);
            mismatches++;
            return;
        end
        e = owed_q.pop_front();
        bytes_checked++;
        if (e.data !== data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, e.data, data);
            mismatches++;
        end
        if (e.last !== last) begin
            $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                     $time, e.last, last);
            mismatches++;
        end
        if (e.done !== done) begin
            $display("%0t: text_done mismatch: expected %0b, actual %0b",
                     $time, e.done, done);
            mismatches++;
        end
    endfunction

    function int pending();
        return owed_q.size();
    endfunction
endclass

module tb_utf16_to_utf8_converter_core;

    // The watchdog fires after this many cycles in which no item moves on
    // either side. The longest correct quiet stretch is the receiver hold-off.
    localparam int WatchdogLimit = 2000;
    localparam int HoldOffCycles = 80;
    localparam int IdlePercent   = 19;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_code_unit;
    logic        i_end_of_text;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_text_done;

    utf8_scoreboard sb;

    // Shared control between the stimulus and the receiver process.
    bit          no_idle;
    bit          rx_hold;
    bit          run_done;
    int unsigned units_sent;
    int unsigned full_cycles;
    int unsigned quiet_cycles;

    utf16_to_utf8_converter_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_code_unit   (i_code_unit),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_text_done   (o_text_done)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Both monitors sample at the rising edge, so they see the values that
    // the edge itself acts on, before any nonblocking update of this step.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            sb.note_unit(i_code_unit, i_end_of_text);
        end
        if (i_rst_n && pop && !empty) begin
            sb.check_byte(o_out_byte, o_last_of_run, o_text_done);
        end
    end

    // Watchdog: a run that stops moving items is a failure. It also counts
    // the cycles in which the block pushed back on the sender.
    always @(posedge i_clk) begin
        if (i_rst_n && !run_done) begin
            if (push && full) begin
                full_cycles <= full_cycles + 1;
            end
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WatchdogLimit) begin
                $display("%0t: watchdog: nothing moved for %0d cycles", $time, WatchdogLimit);
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver. It pops at random, keeps pop high during the no-idle
    // stretch, and on request holds off for a long stretch that it counts
    // itself, so that the block backs up into its input.
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                pop <= 1'b0;
                hold_cnt--;
                if (hold_cnt == 0) begin
                    rx_hold = 1'b0;
                end
            end else if (rx_hold) begin
                pop <= 1'b0;
                hold_cnt = HoldOffCycles;
            end else begin
                pop <= no_idle || ($urandom_range(99) >= IdlePercent);
            end
        end
    end

    // Offers one code unit and returns at the edge where it was taken. The
    // caller is always at a rising edge, so push gets one assignment per step.
    task automatic send_unit(input logic [15:0] cu, input logic eot);
        while (!no_idle && $urandom_range(99) < IdlePercent) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_code_unit   <= cu;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        units_sent++;
    endtask

    // Stops offering and waits until the block owes nothing. The scoreboard
    // is read a little after the edge so that the monitors have run.
    task automatic wait_drained();
        push <= 1'b0;
        do begin
            @(posedge i_clk);
            #1;
        end while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    // One random piece of text. Most of it is well-formed: characters of
    // every encoded length and proper surrogate pairs. The rest is unpaired
    // surrogates and raw 16-bit noise.
    task automatic send_random();
        int          pick;
        logic        eot;
        logic [15:0] cu;
        pick = $urandom_range(99);
        eot  = ($urandom_range(99) < 6);
        if (pick < 30) begin
            cu = 16'($urandom_range(16'h007F));
            send_unit(cu, eot);
        end else if (pick < 45) begin
            cu = 16'($urandom_range(16'h07FF, 16'h0080));
            send_unit(cu, eot);
        end else if (pick < 60) begin
            if ($urandom_range(1) == 0) begin
                cu = 16'($urandom_range(16'hD7FF, 16'h0800));
            end else begin
                cu = 16'($urandom_range(16'hFFFF, 16'hE000));
            end
            send_unit(cu, eot);
        end else if (pick < 85) begin
            cu = 16'($urandom_range(16'hDBFF, 16'hD800));
            send_unit(cu, 1'b0);
            cu = 16'($urandom_range(16'hDFFF, 16'hDC00));
            send_unit(cu, eot);
        end else if (pick < 90) begin
            cu = 16'($urandom_range(16'hDBFF, 16'hD800));
            send_unit(cu, eot);
        end else if (pick < 95) begin
            cu = 16'($urandom_range(16'hDFFF, 16'hDC00));
            send_unit(cu, eot);
        end else begin
            cu = 16'($urandom);
            send_unit(cu, eot);
        end
    endtask

    initial begin : stimulus
        sb            = new();
        no_idle       = 1'b0;
        rx_hold       = 1'b0;
        run_done      = 1'b0;
        units_sent    = 0;
        full_cycles   = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_code_unit   = '0;
        i_end_of_text = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text. First the edges of the 1, 2 and 3 byte ranges
        // around the surrogate block, ending a text on the largest unit.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // The smallest and the largest surrogate pair; the second ends a text.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Low surrogates with no high surrogate before them.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // A held surrogate flushed by a 3-byte character: six bytes at once.
        send_unit(16'hD9AB, 1'b0);
        send_unit(16'h20AC, 1'b0);
        // A held surrogate flushed by another high surrogate, which is then
        // held in turn and flushed by a plain character.
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b0);
        send_unit(16'h0041, 1'b0);
        // A high surrogate at end of text is emitted at once, never held.
        send_unit(16'hDBC0, 1'b1);
        // A held surrogate followed by a high surrogate at end of text.
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDB02, 1'b1);
        // A held surrogate followed by a plain character at end of text.
        send_unit(16'hD802, 1'b0);
        send_unit(16'h0024, 1'b1);

        // Random text with idling on both sides.
        while (units_sent < 100) begin
            send_random();
        end

        // The receiver stops for a long stretch while the sender keeps
        // offering, so the work queue fills and full reaches the sender.
        rx_hold = 1'b1;
        no_idle = 1'b1;
        while (units_sent < 135) begin
            send_random();
        end

        // The sender waits for the block to drain completely, then both
        // sides run without any idle cycle for a while.
        wait_drained();
        while (units_sent < 195) begin
            send_random();
        end
        no_idle = 1'b0;

        while (units_sent < 255) begin
            send_random();
        end

        // Drain, then give the pipeline time to show any stray byte.
        wait_drained();
        repeat (20) @(posedge i_clk);
        run_done = 1'b1;

        $display("Sent %0d code units: %0d surrogate pairs, %0d unpaired surrogates.",
                 sb.units_seen, sb.pairs_seen, sb.lone_seen);
        $display("Compared %0d UTF-8 bytes; the input was held off in %0d cycles.",
                 sb.bytes_checked, full_cycles);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
